/* hw/rtl/tamb_pkg.sv */
// Shared types and constants for the timestamped angle match buffer.
// Used by tamb_rem, tamb_scan and the top level in hw/rtl; depends on nothing.
package tamb_pkg;

    localparam int DEPTH   = 512;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int TIME_W  = 64;
    localparam int STAMP_W = 32;
    localparam int ANGLE_W = 32;
    localparam int CNT_W   = 10;
    localparam int SPAN_W  = 33;
    localparam int CFG_W   = 32;
    localparam int MEM_W   = STAMP_W + ANGLE_W;

    localparam logic [CFG_W-1:0] TOL_RST     = 32'd50000;
    localparam logic [CFG_W-1:0] LIMIT_RST   = 32'd10000000;
    localparam logic [CFG_W-1:0] INVALID_RST = 32'd167772160;
    localparam logic [CFG_W-1:0] WRAP_RST    = 32'd3600000000;

    typedef enum logic [1:0] {
        CFG_TOL     = 2'd0,
        CFG_LIMIT   = 2'd1,
        CFG_INVALID = 2'd2,
        CFG_WRAP    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        FN_ADD   = 1'b0,
        FN_QUERY = 1'b1
    } t_func;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_REM   = 6'b000010,
        S_OLD   = 6'b000100,
        S_SCAN  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic init;
        logic rd_valid;
    } t_scan_ctl;

endpackage

/* hw/rtl/tamb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
module tamb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/tamb_rem.sv */
// Bit-serial remainder unit: 64-bit time modulo a 32-bit period, one bit per cycle.
// Depends on tamb_pkg.
module tamb_rem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tamb_pkg::TIME_W-1:0]      i_dividend,
    input  logic [tamb_pkg::STAMP_W-1:0]     i_divisor,
    output logic                             o_done,
    output logic [tamb_pkg::STAMP_W-1:0]     o_rem
);

    localparam int NW = $clog2(tamb_pkg::TIME_W);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [NW-1:0]                 r_cnt, n_cnt;
    logic [tamb_pkg::TIME_W-1:0]   r_num, n_num;
    logic [tamb_pkg::STAMP_W-1:0]  r_rem, n_rem;
    logic [tamb_pkg::STAMP_W-1:0]  r_div, n_div;
    logic [tamb_pkg::STAMP_W:0]    w_shift;

    assign w_shift = {r_rem, r_num[tamb_pkg::TIME_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_div}) begin
                n_rem = tamb_pkg::STAMP_W'(w_shift - {1'b0, r_div});
            end else begin
                n_rem = tamb_pkg::STAMP_W'(w_shift);
            end
            n_num = {r_num[tamb_pkg::TIME_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == NW'(tamb_pkg::TIME_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/tamb_scan.sv */
// Query datapath: distance stage and best-match tracking over streamed entries.
// Depends on tamb_pkg.
module tamb_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tamb_pkg::t_scan_ctl                 i_ctl,
    input  logic [tamb_pkg::TIME_W-1:0]         i_query,
    input  logic [tamb_pkg::STAMP_W-1:0]        i_stamp,
    input  logic [tamb_pkg::ANGLE_W-1:0]        i_angle,
    input  logic [tamb_pkg::CFG_W-1:0]          i_limit,
    input  logic [tamb_pkg::ANGLE_W-1:0]        i_invalid,
    output logic [tamb_pkg::STAMP_W-1:0]        o_best,
    output logic [tamb_pkg::ANGLE_W-1:0]        o_best_angle,
    output logic                                o_idle
);

    logic [tamb_pkg::TIME_W:0]     w_diff;
    logic [tamb_pkg::TIME_W-1:0]   w_dist;
    logic [tamb_pkg::STAMP_W-1:0]  w_back;

    logic                          r_p2_valid;
    logic                          r_hi_zero;
    logic [tamb_pkg::STAMP_W-1:0]  r_dist;
    logic [tamb_pkg::ANGLE_W-1:0]  r_p2_angle;
    logic [tamb_pkg::STAMP_W-1:0]  r_best;
    logic [tamb_pkg::ANGLE_W-1:0]  r_best_angle;

    assign w_diff = {1'b0, i_query} - {(tamb_pkg::TIME_W - tamb_pkg::STAMP_W + 1)'(0), i_stamp};
    assign w_back = i_stamp - i_query[tamb_pkg::STAMP_W-1:0];
    assign w_dist = w_diff[tamb_pkg::TIME_W] ? tamb_pkg::TIME_W'(w_back)
                                             : w_diff[tamb_pkg::TIME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (i_ctl.init) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= i_ctl.rd_valid;
        end
        r_hi_zero  <= (w_dist[tamb_pkg::TIME_W-1:tamb_pkg::STAMP_W] == '0);
        r_dist     <= w_dist[tamb_pkg::STAMP_W-1:0];
        r_p2_angle <= i_angle;
    end

    // keep strictly smaller only, so the oldest entry wins a tie
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_best       <= i_limit;
            r_best_angle <= i_invalid;
        end else if (r_p2_valid && r_hi_zero && (r_dist < r_best)) begin
            r_best       <= r_dist;
            r_best_angle <= r_p2_angle;
        end
    end

    assign o_best       = r_best;
    assign o_best_angle = r_best_angle;
    assign o_idle       = !r_p2_valid;

endmodule

/* hw/rtl/timestamped_angle_match_buffer_top.sv */
// Top level of the timestamped angle match buffer; uses tamb_pkg, tamb_rem, tamb_ram, tamb_scan.
// An add runs the remainder unit and writes the sample, then fetches the new oldest stamp when
// the store is full; a query sweeps the sample memory one read per cycle, drains the scan
// stage and loads the result register once it is free. One item is in work at a time; the
// result register lets the next item be taken while a result waits. Synchronous active-low
// reset empties the store and loads the register defaults.
module timestamped_angle_match_buffer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_func,
    input  logic [tamb_pkg::TIME_W-1:0]          i_time_us,
    input  logic signed [tamb_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [tamb_pkg::ANGLE_W-1:0]  o_matched_angle,
    output logic                                 o_matched,
    output logic [tamb_pkg::STAMP_W-1:0]         o_fit_us,
    output logic [tamb_pkg::CNT_W-1:0]           o_entry_count,
    output logic signed [tamb_pkg::SPAN_W-1:0]   o_span_us,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_index,
    input  logic [tamb_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int SW = tamb_pkg::CW + 1;

    tamb_pkg::t_state               r_state, n_state;
    logic [tamb_pkg::CFG_W-1:0]     r_tol, r_limit, r_invalid, r_wrap;
    logic [tamb_pkg::AW-1:0]        r_oldest, n_oldest;
    logic [tamb_pkg::CW-1:0]        r_fill, n_fill;
    logic [tamb_pkg::STAMP_W-1:0]   r_newest, n_newest;
    logic [tamb_pkg::STAMP_W-1:0]   r_oldstamp, n_oldstamp;
    logic [tamb_pkg::TIME_W-1:0]    r_q, n_q;
    logic [tamb_pkg::ANGLE_W-1:0]   r_ang, n_ang;
    logic [tamb_pkg::CW-1:0]        r_k, n_k;
    logic [tamb_pkg::AW-1:0]        r_ptr, n_ptr;
    logic                           r_rd_pend, n_rd_pend;

    logic                           r_out_valid, n_out_valid;
    logic [tamb_pkg::ANGLE_W-1:0]   r_out_angle, n_out_angle;
    logic                           r_out_matched, n_out_matched;
    logic [tamb_pkg::STAMP_W-1:0]   r_out_fit, n_out_fit;
    logic [tamb_pkg::CNT_W-1:0]     r_out_count, n_out_count;
    logic [tamb_pkg::SPAN_W-1:0]    r_out_span, n_out_span;

    logic                           w_accept;
    logic                           w_full;
    logic [SW-1:0]                  w_sum;
    logic [tamb_pkg::AW-1:0]        w_slot;
    logic [tamb_pkg::AW-1:0]        w_next_old;
    logic [tamb_pkg::STAMP_W-1:0]   w_stamp;

    logic                           w_rem_start, w_rem_done;
    logic [tamb_pkg::STAMP_W-1:0]   w_rem;

    logic                           w_we;
    logic [tamb_pkg::AW-1:0]        w_raddr;
    logic [tamb_pkg::MEM_W-1:0]     w_rdata;

    tamb_pkg::t_scan_ctl            w_scan_ctl;
    logic [tamb_pkg::STAMP_W-1:0]   w_best;
    logic [tamb_pkg::ANGLE_W-1:0]   w_best_angle;
    logic                           w_scan_idle;

    assign o_stall  = (r_state != tamb_pkg::S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_fill == tamb_pkg::CW'(tamb_pkg::DEPTH));

    assign w_sum  = SW'(r_oldest) + SW'(r_fill);
    assign w_slot = (w_sum >= SW'(tamb_pkg::DEPTH)) ? tamb_pkg::AW'(w_sum - SW'(tamb_pkg::DEPTH))
                                                    : tamb_pkg::AW'(w_sum);
    assign w_next_old = (r_oldest == tamb_pkg::AW'(tamb_pkg::DEPTH - 1)) ? '0
                                                                         : r_oldest + 1'b1;
    assign w_stamp = (r_wrap == '0) ? r_q[tamb_pkg::STAMP_W-1:0] : w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= tamb_pkg::TOL_RST;
            r_limit   <= tamb_pkg::LIMIT_RST;
            r_invalid <= tamb_pkg::INVALID_RST;
            r_wrap    <= tamb_pkg::WRAP_RST;
        end else if (i_cfg_we) begin
            unique case (tamb_pkg::t_cfg_idx'(i_cfg_index))
                tamb_pkg::CFG_TOL:     r_tol     <= i_cfg_data;
                tamb_pkg::CFG_LIMIT:   r_limit   <= i_cfg_data;
                tamb_pkg::CFG_INVALID: r_invalid <= i_cfg_data;
                tamb_pkg::CFG_WRAP:    r_wrap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state       = r_state;
        n_oldest      = r_oldest;
        n_fill        = r_fill;
        n_newest      = r_newest;
        n_oldstamp    = r_oldstamp;
        n_q           = r_q;
        n_ang         = r_ang;
        n_k           = r_k;
        n_ptr         = r_ptr;
        n_rd_pend     = 1'b0;
        n_out_valid   = r_out_valid && i_stall;
        n_out_angle   = r_out_angle;
        n_out_matched = r_out_matched;
        n_out_fit     = r_out_fit;
        n_out_count   = r_out_count;
        n_out_span    = r_out_span;
        w_rem_start   = 1'b0;
        w_we          = 1'b0;
        w_raddr       = w_next_old;
        w_scan_ctl    = '0;
        w_scan_ctl.rd_valid = r_rd_pend;

        unique case (r_state)
            tamb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_q   = i_time_us;
                    n_ang = i_angle;
                    if (tamb_pkg::t_func'(i_func) == tamb_pkg::FN_ADD) begin
                        w_rem_start = 1'b1;
                        n_state     = tamb_pkg::S_REM;
                    end else begin
                        w_scan_ctl.init = 1'b1;
                        n_k     = '0;
                        n_ptr   = r_oldest;
                        n_state = tamb_pkg::S_SCAN;
                    end
                end
            end
            tamb_pkg::S_REM: begin
                if (w_rem_done) begin
                    w_we     = 1'b1;
                    n_newest = w_stamp;
                    if (w_full) begin
                        // overwrite oldest, advance and fetch the new oldest stamp
                        n_oldest = w_next_old;
                        n_state  = tamb_pkg::S_OLD;
                    end else begin
                        n_fill = r_fill + 1'b1;
                        if (r_fill == '0) begin
                            n_oldstamp = w_stamp;
                        end
                        n_state = tamb_pkg::S_IDLE;
                    end
                end
            end
            tamb_pkg::S_OLD: begin
                n_oldstamp = w_rdata[tamb_pkg::STAMP_W-1:0];
                n_state    = tamb_pkg::S_IDLE;
            end
            tamb_pkg::S_SCAN: begin
                if (r_k != r_fill) begin
                    w_raddr   = r_ptr;
                    n_rd_pend = 1'b1;
                    n_k       = r_k + 1'b1;
                    n_ptr     = (r_ptr == tamb_pkg::AW'(tamb_pkg::DEPTH - 1)) ? '0
                                                                              : r_ptr + 1'b1;
                end else begin
                    n_state = tamb_pkg::S_DRAIN;
                end
            end
            tamb_pkg::S_DRAIN: begin
                if (!r_rd_pend && w_scan_idle) begin
                    n_state = tamb_pkg::S_DONE;
                end
            end
            tamb_pkg::S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_angle   = w_best_angle;
                    n_out_matched = (w_best < r_tol);
                    n_out_fit     = w_best;
                    n_out_count   = tamb_pkg::CNT_W'(r_fill);
                    n_out_span    = {1'b0, r_newest} - {1'b0, r_oldstamp};
                    n_state       = tamb_pkg::S_IDLE;
                end
            end
            default: n_state = tamb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tamb_pkg::S_IDLE;
            r_oldest    <= '0;
            r_fill      <= '0;
            r_newest    <= '0;
            r_oldstamp  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_fill      <= n_fill;
            r_newest    <= n_newest;
            r_oldstamp  <= n_oldstamp;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            r_k         <= n_k;
        end
        r_q           <= n_q;
        r_ang         <= n_ang;
        r_ptr         <= n_ptr;
        r_out_angle   <= n_out_angle;
        r_out_matched <= n_out_matched;
        r_out_fit     <= n_out_fit;
        r_out_count   <= n_out_count;
        r_out_span    <= n_out_span;
    end

    tamb_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (n_q),
        .i_divisor  (r_wrap),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    tamb_ram #(
        .WIDTH (tamb_pkg::MEM_W),
        .DEPTH (tamb_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata ({r_ang, w_stamp}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tamb_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_query      (r_q),
        .i_stamp      (w_rdata[tamb_pkg::STAMP_W-1:0]),
        .i_angle      (w_rdata[tamb_pkg::MEM_W-1:tamb_pkg::STAMP_W]),
        .i_limit      (r_limit),
        .i_invalid    (r_invalid),
        .o_best       (w_best),
        .o_best_angle (w_best_angle),
        .o_idle       (w_scan_idle)
    );

    assign o_valid         = r_out_valid;
    assign o_matched_angle = r_out_angle;
    assign o_matched       = r_out_matched;
    assign o_fit_us        = r_out_fit;
    assign o_entry_count   = r_out_count;
    assign o_span_us       = r_out_span;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= tamb_pkg::CW'(tamb_pkg::DEPTH))
        else $error("fill count beyond store depth");

    a_oldest_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> (r_oldest == '0))
        else $error("oldest index moved before the store filled");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == tamb_pkg::S_DONE))
        else $error("result raised outside query completion");

    a_read_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == tamb_pkg::S_SCAN || r_state == tamb_pkg::S_DRAIN))
        else $error("scan read outstanding outside a query");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for timestamped_angle_match_buffer_top: a directed table, then
// random add/query traffic under several register settings, checked by a predictor.
// Depends on tamb_pkg and the block's RTL only.
module testbench;
    import tamb_pkg::*;

    localparam int NDIR      = 27;
    localparam int MAX_CYC   = 4000000;
    localparam int HOLD_CYC  = 3000;
    localparam int QUIET_CYC = 100;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               matched;
        logic [STAMP_W-1:0] fit;
        logic [CNT_W-1:0]   count;
        logic [SPAN_W-1:0]  span;
    } t_match_res;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PRED,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_cfg_idx          idx;
        t_func             func;
        logic [TIME_W-1:0] t_us;
        logic [CFG_W-1:0]  data;
        t_match_res        want;
    } t_dir_row;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic                      o_stall;
    logic                      i_func      = 1'b0;
    logic [TIME_W-1:0]         i_time_us   = '0;
    logic signed [ANGLE_W-1:0] i_angle     = '0;
    logic                      o_valid;
    logic                      i_stall     = 1'b0;
    logic signed [ANGLE_W-1:0] o_matched_angle;
    logic                      o_matched;
    logic [STAMP_W-1:0]        o_fit_us;
    logic [CNT_W-1:0]          o_entry_count;
    logic signed [SPAN_W-1:0]  o_span_us;
    logic                      i_cfg_we    = 1'b0;
    logic [1:0]                i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data  = '0;

    // predictor state
    logic [CFG_W-1:0]   cfg_tol;
    logic [CFG_W-1:0]   cfg_limit;
    logic [CFG_W-1:0]   cfg_invalid;
    logic [CFG_W-1:0]   cfg_wrap;
    logic [STAMP_W-1:0] stamp_mem [DEPTH];
    logic [ANGLE_W-1:0] angle_mem [DEPTH];
    int                 store_head;
    int                 store_fill;
    logic [STAMP_W-1:0] newest_stamp;
    logic [STAMP_W-1:0] oldest_stamp;

    t_match_res         exp_fifo [EXP_DEPTH];
    int                 exp_wr    = 0;
    int                 exp_rd    = 0;
    t_dir_row           dir_tab [NDIR];
    int                 err_cnt   = 0;
    int                 cyc_cnt   = 0;
    int                 hold_req  = 0;
    int                 hold_ack  = 0;
    int                 hold_left = 0;
    bit                 no_idle   = 1'b0;
    logic [TIME_W-1:0]  base_us   = '0;
    logic [TIME_W-1:0]  last_add_us = '0;

    timestamped_angle_match_buffer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_time_us       (i_time_us),
        .i_angle         (i_angle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_matched_angle (o_matched_angle),
        .o_matched       (o_matched),
        .o_fit_us        (o_fit_us),
        .o_entry_count   (o_entry_count),
        .o_span_us       (o_span_us),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit predict_match(input t_func f, input logic [TIME_W-1:0] t,
                                         input logic [ANGLE_W-1:0] a, output t_match_res r);
        logic [STAMP_W-1:0] stamp;
        logic [TIME_W-1:0]  best;
        logic [TIME_W-1:0]  s;
        logic [TIME_W-1:0]  d;
        logic [ANGLE_W-1:0] best_ang;
        int                 slot;
        int                 k;
        r = '0;
        if (f == FN_ADD) begin
            stamp = (cfg_wrap == '0) ? t[STAMP_W-1:0] : STAMP_W'(t % {32'h0, cfg_wrap});
            slot = (store_head + store_fill) % DEPTH;
            stamp_mem[slot] = stamp;
            angle_mem[slot] = a;
            if (store_fill < DEPTH) store_fill++;
            else store_head = (store_head + 1) % DEPTH;
            oldest_stamp = stamp_mem[store_head];
            newest_stamp = stamp;
            return 1'b0;
        end
        best     = {32'h0, cfg_limit};
        best_ang = cfg_invalid;
        for (k = 0; k < store_fill; k++) begin
            slot = (store_head + k) % DEPTH;
            s = {32'h0, stamp_mem[slot]};
            d = (t >= s) ? t - s : s - t;
            if (d < best) begin
                best     = d;
                best_ang = angle_mem[slot];
            end
        end
        r.angle   = best_ang;
        r.matched = (best < {32'h0, cfg_tol});
        r.fit     = best[STAMP_W-1:0];
        r.count   = CNT_W'(store_fill);
        r.span    = {1'b0, newest_stamp} - {1'b0, oldest_stamp};
        return 1'b1;
    endfunction

    task automatic send_item(input t_func f, input logic [TIME_W-1:0] t,
                             input logic [ANGLE_W-1:0] a, input bit typed,
                             input t_match_res want);
        t_match_res pred;
        if (!no_idle) begin
            while ($urandom_range(99) < 22) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_func    <= f;
        i_time_us <= t;
        i_angle   <= a;
        do @(posedge i_clk); while (o_stall);
        if (predict_match(f, t, a, pred)) begin
            exp_fifo[exp_wr % EXP_DEPTH] = typed ? want : pred;
            exp_wr++;
        end
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (QUIET_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TOL:     cfg_tol     = v;
            CFG_LIMIT:   cfg_limit   = v;
            CFG_INVALID: cfg_invalid = v;
            CFG_WRAP:    cfg_wrap    = v;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] tol, input logic [CFG_W-1:0] lim,
                              input logic [CFG_W-1:0] inv, input logic [CFG_W-1:0] wrap);
        wait_quiet();
        cfg_write(CFG_TOL, tol);
        cfg_write(CFG_LIMIT, lim);
        cfg_write(CFG_INVALID, inv);
        cfg_write(CFG_WRAP, wrap);
    endtask

    task automatic random_items(input int n, input int add_pct);
        logic [TIME_W-1:0]  t;
        logic [ANGLE_W-1:0] a;
        int                 m;
        int                 w;
        int                 k;
        int                 i;
        for (i = 0; i < n; i++) begin
            a = $urandom;
            m = $urandom_range(99);
            if ($urandom_range(99) < add_pct) begin
                if (m < 70) begin
                    base_us += $urandom_range(1, 3000);
                    t = base_us;
                end else if (m < 80) begin
                    t = last_add_us;
                end else if (m < 90) begin
                    t = {$urandom, $urandom};
                end else begin
                    t = {32'h0, $urandom};
                end
                if ($urandom_range(19) == 0) a = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
                last_add_us = t;
                send_item(FN_ADD, t, a, 1'b0, '0);
            end else begin
                w = $urandom_range(1) ? 64 : 100000;
                k = 0;
                if (store_fill > 0) k = (store_head + $urandom_range(0, store_fill - 1)) % DEPTH;
                if (store_fill == 0 || m >= 55) begin
                    if (m < 70) begin
                        t = {$urandom, $urandom};
                    end else if (m < 85) begin
                        t = {32'h0, $urandom};
                    end else begin
                        case ($urandom_range(3))
                            0:       t = '0;
                            1:       t = '1;
                            2:       t = 64'h0000_0000_FFFF_FFFF;
                            default: t = {32'h0, cfg_limit};
                        endcase
                    end
                end else if (m < 35) begin
                    t = {32'h0, stamp_mem[k]} + 64'($urandom_range(0, 2 * w)) - 64'(w);
                end else begin
                    t = {32'h0, stamp_mem[k]};
                end
                send_item(FN_QUERY, t, a, 1'b0, '0);
            end
        end
    endtask

    task automatic flag_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin : rx
        t_match_res want;
        t_match_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_matched_angle, o_matched, o_fit_us, o_entry_count, o_span_us};
            if (exp_wr == exp_rd) begin
                flag_field("unrequested result angle", '0, got.angle);
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.angle !== want.angle) flag_field("matched_angle", want.angle, got.angle);
                if (got.matched !== want.matched) flag_field("matched", want.matched, got.matched);
                if (got.fit !== want.fit) flag_field("fit_us", want.fit, got.fit);
                if (got.count !== want.count) flag_field("entry_count", want.count, got.count);
                if (got.span !== want.span) flag_field("span_us", want.span, got.span);
            end
        end
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (no_idle) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= MAX_CYC) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : main
        int r;
        cfg_tol      = TOL_RST;
        cfg_limit    = LIMIT_RST;
        cfg_invalid  = INVALID_RST;
        cfg_wrap     = WRAP_RST;
        store_head   = 0;
        store_fill   = 0;
        newest_stamp = '0;
        oldest_stamp = '0;
        dir_tab = '{
            '{ROW_CFG,   CFG_TOL,     FN_ADD,   64'd0,   32'd100,       '0},
            '{ROW_CFG,   CFG_LIMIT,   FN_ADD,   64'd0,   32'd99,        '0},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd5,   32'd0,
              '{32'd167772160, 1'b1, 32'd99, 10'd0, 33'd0}},
            '{ROW_CFG,   CFG_LIMIT,   FN_ADD,   64'd0,   32'd10000000,  '0},
            '{ROW_CFG,   CFG_TOL,     FN_ADD,   64'd0,   32'd50000,     '0},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd0,   32'd0,
              '{32'd167772160, 1'b0, 32'd10000000, 10'd0, 33'd0}},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, '1,      32'd0,
              '{32'd167772160, 1'b0, 32'd10000000, 10'd0, 33'd0}},
            '{ROW_PRED,  CFG_TOL,     FN_ADD,   64'd1000, 32'h7FFFFFFF, '0},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd1000, 32'd0,
              '{32'h7FFFFFFF, 1'b1, 32'd0, 10'd1, 33'd0}},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd51000, 32'd0,
              '{32'h7FFFFFFF, 1'b0, 32'd50000, 10'd1, 33'd0}},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd50999, 32'd0,
              '{32'h7FFFFFFF, 1'b1, 32'd49999, 10'd1, 33'd0}},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd10001000, 32'd0,
              '{32'd167772160, 1'b0, 32'd10000000, 10'd1, 33'd0}},
            '{ROW_PRED,  CFG_TOL,     FN_ADD,   64'd3000, 32'h80000000, '0},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd2000, 32'd0,
              '{32'h7FFFFFFF, 1'b1, 32'd1000, 10'd2, 33'd2000}},
            '{ROW_PRED,  CFG_TOL,     FN_ADD,   64'd3600000000, 32'h12345678, '0},
            '{ROW_TYPED, CFG_TOL,     FN_QUERY, 64'd0,   32'd0,
              '{32'h12345678, 1'b1, 32'd0, 10'd3, 33'h1_FFFF_FC18}},
            '{ROW_PRED,  CFG_TOL,     FN_ADD,   '1,      32'hFFFFFFFF,  '0},
            '{ROW_PRED,  CFG_TOL,     FN_QUERY, '1,      32'd0,         '0},
            '{ROW_PRED,  CFG_TOL,     FN_QUERY, 64'h0000_0001_0000_0000, 32'd0, '0},
            '{ROW_PRED,  CFG_TOL,     FN_ADD,   64'd5000, 32'd1,        '0},
            '{ROW_PRED,  CFG_TOL,     FN_ADD,   64'd5000, 32'd2,        '0},
            '{ROW_PRED,  CFG_TOL,     FN_QUERY, 64'd5000, 32'd0,        '0},
            '{ROW_CFG,   CFG_INVALID, FN_ADD,   64'd0,   32'h80000000,  '0},
            '{ROW_CFG,   CFG_WRAP,    FN_ADD,   64'd0,   32'd0,         '0},
            '{ROW_PRED,  CFG_TOL,     FN_ADD,   64'h1234_5678_9ABC_DEF0, 32'd3, '0},
            '{ROW_PRED,  CFG_TOL,     FN_QUERY, 64'h0000_0000_9ABC_DEF0, 32'd0, '0},
            '{ROW_PRED,  CFG_TOL,     FN_QUERY, 64'h0000_0002_0000_0000, 32'd0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NDIR; r++) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                wait_quiet();
                cfg_write(dir_tab[r].idx, dir_tab[r].data);
            end else begin
                send_item(dir_tab[r].func, dir_tab[r].t_us, dir_tab[r].data,
                          dir_tab[r].kind == ROW_TYPED, dir_tab[r].want);
            end
        end

        set_config(32'd50000, 32'd10000000, $urandom, 32'd3600000000);
        random_items(200, 80);
        set_config(32'd0, 32'd3600000000, 32'h80000000, 32'd1);
        random_items(150, 60);
        set_config(32'd3600000000, 32'd0, 32'h7FFFFFFF, 32'hFFFFFFFF);
        random_items(150, 60);
        set_config($urandom_range(0, 200000), $urandom_range(0, 20000000), $urandom, 32'd0);
        random_items(150, 55);

        no_idle = 1'b1;
        set_config($urandom_range(0, 100000), $urandom_range(0, 3600000000), $urandom,
                   $urandom_range(1, 3600000000));
        random_items(200, 55);
        no_idle = 1'b0;

        // hold off the receiver and keep offering queries so the input backs up
        hold_req++;
        random_items(20, 0);

        set_config(32'd10, 32'd500, $urandom, 32'd1000);
        random_items(150, 55);
        set_config($urandom_range(0, 3600000000), $urandom_range(0, 3600000000), $urandom,
                   $urandom_range(1, 32'hFFFFFFFF));
        random_items(130, 55);

        wait_quiet();
        if (err_cnt == 0 && exp_wr == exp_rd) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/tamb_pkg.sv
hw/rtl/tamb_ram.sv
hw/rtl/tamb_rem.sv
hw/rtl/tamb_scan.sv
hw/rtl/timestamped_angle_match_buffer_top.sv
test/testbench.sv
